@@ src/bal_pkg.sv @@
`default_nettype none

package bal_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  count;
    } res_t;

endpackage

`default_nettype wire

@@ src/bounded_array_list.sv @@
// Append, update and any failed word go from acceptance straight to the done state, a read
// passes through the read-wait state first, and a remove through the shift loop.
// Throughput: one word at a time; the next word is taken in the cycle after a result is
// handed to the output register, and a remove shifts one entry per cycle.
// The shift loop is bound by the single read and single write port of the entry memory.
// Reset clears the count, the state machine and the output valid and sets capacity to 256.
`default_nettype none

module bounded_array_list
    import bal_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [DATA_W-1:0] entry_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic [DATA_W-1:0]      read_data,
    output logic [CNT_W-1:0]       count
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CLIP = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);

    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[AW-1:0];
    endfunction

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] mem_q;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             pend_reg, pend_next;
    res_t             res_reg, res_next;

    logic             load_ready;
    logic             load_valid;
    logic [63:0]      din_wide;
    logic [63:0]      q_wide;
    logic [CNT_W-1:0] idx_ext;
    logic             idx_ok;

    assign din_wide = 64'(entry_data);
    assign q_wide   = 64'(mem_q);
    assign idx_ext  = {1'b0, index};
    assign idx_ok   = idx_ext < count_reg;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = to_addr(count_reg);
        mem_wdata    = din_wide[ENTRY_WIDTH-1:0];
        mem_raddr    = to_addr(idx_ext);
        load_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.ok        = 1'b0;
                    res_next.read_data = '0;
                    res_next.count     = count_reg;
                    state_next         = S_DONE;
                    case (action_t'(action))
                        ACT_APPEND:
                        begin
                            if (count_reg < cap_reg && count_reg < DEPTH_CLIP)
                            begin
                                mem_we         = 1'b1;
                                count_next     = count_reg + 9'd1;
                                res_next.ok    = 1'b1;
                                res_next.count = count_reg + 9'd1;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (idx_ok)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = to_addr(idx_ext);
                                res_next.ok = 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                ptr_next   = idx_ext;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_next.ok        = 1'b1;
                res_next.read_data = q_wide[DATA_W-1:0];
                res_next.count     = count_reg;
                state_next         = S_DONE;
            end
            S_SHIFT:
            begin
                // Each moved entry is read in the cycle before its write one place lower.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = mem_q;
                end
                if (({1'b0, ptr_reg} + 10'd1) < {1'b0, count_reg})
                begin
                    mem_raddr    = to_addr(ptr_reg + 9'd1);
                    pend_next    = 1'b1;
                    wr_addr_next = to_addr(ptr_reg);
                    ptr_next     = ptr_reg + 9'd1;
                end
                else
                begin
                    pend_next          = 1'b0;
                    count_next         = count_reg - 9'd1;
                    res_next.ok        = 1'b1;
                    res_next.read_data = '0;
                    res_next.count     = count_reg - 9'd1;
                    state_next         = S_DONE;
                end
            end
            S_DONE:
            begin
                load_valid = 1'b1;
                if (load_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
    end

    bal_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_res   (res_reg),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .read_data  (read_data),
        .count      (count)
    );

endmodule

`default_nettype wire

@@ src/bal_out.sv @@
`default_nettype none

module bal_out
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    input  wire res_t              load_res,
    output logic                   load_ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic [DATA_W-1:0]      read_data,
    output logic [CNT_W-1:0]       count
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign load_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign ok        = res_reg.ok;
    assign read_data = res_reg.read_data;
    assign count     = res_reg.count;

endmodule

`default_nettype wire

@@ src/bal_checker.sv @@
`default_nettype none

module bal_checker
    import bal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic              ok,
    input wire logic [DATA_W-1:0] read_data,
    input wire logic [CNT_W-1:0]  count
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(count) <= 32'(DEPTH)))
        else $error("count exceeds the list depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (read_data == '0))
        else $error("failed word carries nonzero read data");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word taken while one is still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(read_data)
                                      && $stable(count)))
        else $error("stalled result changed");

endmodule

bind bounded_array_list bal_checker #(.DEPTH(DEPTH)) u_bal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .read_data (read_data),
    .count     (count)
);

`default_nettype wire

@@ dv/bounded_array_list_test.sv @@
module bounded_array_list_test;
    import bal_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        action = ACT_APPEND;
    logic [IDX_W-1:0]  index = '0;
    logic [DATA_W-1:0] entry_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  count;

    logic [DATA_W-1:0] list_mem [DEPTH_DEF];
    int                list_count = 0;
    int                list_cap = int'(CAP_RESET);

    res_t              expected_replies [$];
    res_t              want;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                stall_left = 0;
    bit                quiet_mode = 1'b0;

    bounded_array_list DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .index      (index),
        .entry_data (entry_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .read_data  (read_data),
        .count      (count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Applies one request to the list kept by the testbench and returns its result.
    function automatic res_t apply_request(action_t act, logic [IDX_W-1:0] idx,
                                           logic [DATA_W-1:0] d);
        res_t r;
        int   lim;
        r = '0;
        lim = (list_cap > DEPTH_DEF) ? DEPTH_DEF : list_cap;
        case (act)
            ACT_APPEND:
                if (list_count < lim)
                begin
                    list_mem[list_count] = d;
                    list_count++;
                    r.ok = 1'b1;
                end
            ACT_UPDATE:
                if (int'(idx) < list_count)
                begin
                    list_mem[idx] = d;
                    r.ok = 1'b1;
                end
            ACT_REMOVE:
                if (int'(idx) < list_count)
                begin
                    for (int i = int'(idx); i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_count--;
                    r.ok = 1'b1;
                end
            default:
                if (int'(idx) < list_count)
                begin
                    r.read_data = list_mem[idx];
                    r.ok = 1'b1;
                end
        endcase
        r.count = list_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        $display("Mismatch on %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, exp_val);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("word with nothing expected", read_data, '0);
            else
            begin
                want = expected_replies.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", DATA_W'(ok), DATA_W'(want.ok));
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (count !== want.count)
                    report_mismatch("count", DATA_W'(count), DATA_W'(want.count));
            end
        end
    end

    task automatic send_word(input action_t act, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        index <= idx;
        entry_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_replies.push_back(apply_request(act, idx, d));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        list_cap = int'(cap);
    endtask

    task automatic test_empty_list();
        send_word(ACT_READ, 8'd0, 32'h0);
        send_word(ACT_REMOVE, 8'd0, 32'h0);
        send_word(ACT_UPDATE, 8'd255, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_actions();
        send_word(ACT_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, 8'd0, 32'h0000_0000);
        send_word(ACT_APPEND, 8'd0, 32'hA5A5_A5A5);
        send_word(ACT_APPEND, 8'd0, 32'h5A5A_5A5A);
        send_word(ACT_READ, 8'd0, 32'h0);
        send_word(ACT_READ, 8'd3, 32'h0);
        send_word(ACT_READ, 8'd4, 32'h0);
        send_word(ACT_UPDATE, 8'd1, 32'h1234_5678);
        send_word(ACT_READ, 8'd1, 32'h0);
        send_word(ACT_REMOVE, 8'd0, 32'h0);
        send_word(ACT_READ, 8'd0, 32'h0);
        send_word(ACT_REMOVE, 8'd2, 32'h0);
        send_word(ACT_READ, 8'd255, 32'h0);
        send_word(ACT_UPDATE, 8'd200, 32'hDEAD_BEEF);
    endtask

    task automatic test_capacity_limits();
        // Capacity below the count: appends fail, held entries stay reachable.
        write_capacity(9'd1);
        send_word(ACT_APPEND, 8'd0, 32'h1111_1111);
        send_word(ACT_READ, 8'd1, 32'h0);
        send_word(ACT_UPDATE, 8'd0, 32'h8000_0001);
        write_capacity(9'd0);
        send_word(ACT_APPEND, 8'd0, 32'h2222_2222);
        send_word(ACT_REMOVE, 8'd1, 32'h0);
        send_word(ACT_APPEND, 8'd0, 32'h3333_3333);
        write_capacity(9'd3);
        send_word(ACT_APPEND, 8'd0, 32'h4444_4444);
        send_word(ACT_APPEND, 8'd0, 32'h5555_5555);
        send_word(ACT_APPEND, 8'd0, 32'h6666_6666);
        write_capacity(9'd300);
        send_word(ACT_APPEND, 8'd0, 32'h7777_7777);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] cap, input int n_words,
                             input int append_pct, input bit quiet);
        action_t          act;
        logic [IDX_W-1:0] idx;
        write_capacity(cap);
        quiet_mode = quiet;
        repeat (n_words)
        begin
            if ($urandom_range(0, 99) < append_pct)
                act = ACT_APPEND;
            else
                act = action_t'($urandom_range(1, 3));
            if (list_count > 0 && $urandom_range(0, 9) != 0)
                idx = IDX_W'($urandom_range(0, list_count - 1));
            else
                idx = IDX_W'($urandom_range(0, 255));
            send_word(act, idx, $urandom);
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_phase(9'd256, 420, 65, 1'b0);
        run_phase(9'd130, 150, 50, 1'b1);
        run_phase(9'd511, 200, 20, 1'b0);
        run_phase(9'd0, 80, 30, 1'b0);
        run_phase(9'd1, 120, 50, 1'b0);
        run_phase(CNT_W'($urandom_range(2, 40)), 175, 45, 1'b0);
        run_phase(CNT_W'($urandom_range(2, 40)), 175, 45, 1'b1);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_actions();
        test_capacity_limits();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/bal_pkg.sv
src/bal_out.sv
src/bounded_array_list.sv
src/bal_checker.sv
dv/bounded_array_list_test.sv
